// File: rtl/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared constants and types for the LRU key-value cache core.
// ----------------------------------------------------------------------------
package lrukv_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CFG_BITS     = 5;
    localparam int PADDR_BITS   = 3;
    localparam int PDATA_BITS   = 32;
    localparam int REG_IDX_BITS = PADDR_BITS - 2;

    localparam logic [CFG_BITS-1:0]     CAP_RESET        = 5'd16;
    localparam logic [REG_IDX_BITS-1:0] REG_CAPACITY_IDX = '0;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic                  psel;
        logic                  penable;
        logic                  pwrite;
        logic [PADDR_BITS-1:0] paddr;
        logic [PDATA_BITS-1:0] pwdata;
    } apb_req_t;

endpackage

// File: rtl/lrukv_regs.sv
// ----------------------------------------------------------------------------
// lrukv_regs
// APB register file: holds the capacity_in_use register.
// ----------------------------------------------------------------------------
module lrukv_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lrukv_pkg::apb_req_t                 apb_req,
    output logic [lrukv_pkg::PDATA_BITS-1:0]    prdata,
    output logic                                pready,
    output logic [lrukv_pkg::CFG_BITS-1:0]      cap_cfg
);

    logic [lrukv_pkg::CFG_BITS-1:0] cap_reg;
    logic [lrukv_pkg::CFG_BITS-1:0] cap_next;
    logic                           sel_cap;

    assign pready  = 1'b1;
    assign sel_cap = (apb_req.paddr[lrukv_pkg::PADDR_BITS-1:2] == lrukv_pkg::REG_CAPACITY_IDX);

    always_comb
    begin
        cap_next = cap_reg;
        if (apb_req.psel && apb_req.penable && apb_req.pwrite && pready && sel_cap)
        begin
            cap_next = apb_req.pwdata[lrukv_pkg::CFG_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lrukv_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign prdata  = sel_cap ? lrukv_pkg::PDATA_BITS'(cap_reg) : '0;
    assign cap_cfg = cap_reg;

endmodule

// File: rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with LRU replacement and per-entry ranks.
// ----------------------------------------------------------------------------
// Result strobe (done): start is captured in in_vld_reg, which feeds done_reg.
// Throughput: one transaction per cycle; busy stays low, the single compute
//   stage between the input and result registers updates all entries at once.
// Reset: cache empty, occupancy zero, capacity_in_use = 16; results cannot stall.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
    parameter int CAPACITY   = lrukv_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrukv_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [lrukv_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [lrukv_pkg::PDATA_BITS-1:0]    prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic                                kind,
    input  logic [KEY_BITS-1:0]                 lookup_key,
    input  logic signed [VALUE_BITS-1:0]        write_value,
    output logic                                done,
    output logic                                hit,
    output logic signed [31:0]                  read_value,
    output logic                                evicted,
    output logic [KEY_BITS-1:0]                 evicted_key
);

    localparam int RANK_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_BITS  = $clog2(CAPACITY + 1);
    localparam int CW        = (OCC_BITS > lrukv_pkg::CFG_BITS) ? OCC_BITS + 1
                                                                : lrukv_pkg::CFG_BITS + 1;

    lrukv_pkg::apb_req_t            apb_req;
    logic [lrukv_pkg::CFG_BITS-1:0] cap_cfg;

    assign apb_req.psel    = psel;
    assign apb_req.penable = penable;
    assign apb_req.pwrite  = pwrite;
    assign apb_req.paddr   = paddr;
    assign apb_req.pwdata  = pwdata;

    lrukv_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .apb_req (apb_req),
        .prdata  (prdata),
        .pready  (pready),
        .cap_cfg (cap_cfg)
    );

    // input stage
    logic                  in_vld_reg;
    logic                  in_kind_reg;
    logic [KEY_BITS-1:0]   in_key_reg;
    logic [VALUE_BITS-1:0] in_val_reg;

    // entry state
    logic [CAPACITY-1:0]   valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg   [CAPACITY];
    logic [KEY_BITS-1:0]   key_next  [CAPACITY];
    logic [VALUE_BITS-1:0] value_reg [CAPACITY];
    logic [VALUE_BITS-1:0] value_next[CAPACITY];
    logic [RANK_BITS-1:0]  rank_reg  [CAPACITY];
    logic [RANK_BITS-1:0]  rank_next [CAPACITY];
    logic [OCC_BITS-1:0]   occ_reg, occ_next;

    // result stage
    logic                  done_reg, done_next;
    logic                  hit_reg, hit_next;
    logic signed [31:0]    rd_reg, rd_next;
    logic                  ev_reg, ev_next;
    logic [KEY_BITS-1:0]   evk_reg, evk_next;

    logic [CAPACITY-1:0]   match_v;
    logic [CAPACITY-1:0]   inv_v;
    logic [CAPACITY-1:0]   free_oh;
    logic [CAPACITY-1:0]   lru_oh;
    logic [CAPACITY-1:0]   tgt_oh;
    logic                  hit_c;
    logic                  full_c;
    logic [CW-1:0]         eff_cap;
    logic [RANK_BITS-1:0]  hit_rank;
    logic [RANK_BITS-1:0]  lru_rank;
    logic [VALUE_BITS-1:0] hit_val;
    logic signed [VALUE_BITS-1:0] hit_val_s;
    logic [KEY_BITS-1:0]   lru_key;

    assign busy = 1'b0;

    always_comb
    begin
        if (cap_cfg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (CW'(cap_cfg) > CW'(CAPACITY))
        begin
            eff_cap = CW'(CAPACITY);
        end
        else
        begin
            eff_cap = CW'(cap_cfg);
        end
    end

    assign full_c   = (CW'(occ_reg) >= eff_cap);
    assign lru_rank = RANK_BITS'(occ_reg - 1'b1);
    assign inv_v    = ~valid_reg;
    assign free_oh  = inv_v & (~inv_v + 1'b1);
    assign hit_c    = |match_v;
    assign tgt_oh   = full_c ? lru_oh : free_oh;
    assign hit_val_s = hit_val;

    // parallel key compare and one-hot reads
    always_comb
    begin
        hit_val  = '0;
        hit_rank = '0;
        lru_key  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_v[i] = valid_reg[i] && (key_reg[i] == in_key_reg);
            lru_oh[i]  = valid_reg[i] && (rank_reg[i] == lru_rank);
            if (match_v[i])
            begin
                hit_val  = hit_val | value_reg[i];
                hit_rank = hit_rank | rank_reg[i];
            end
            if (lru_oh[i])
            begin
                lru_key = lru_key | key_reg[i];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
            rank_next[i]  = rank_reg[i];
        end
        done_next = in_vld_reg;
        hit_next  = hit_c;
        rd_next   = '0;
        ev_next   = 1'b0;
        evk_next  = '0;

        if (in_vld_reg)
        begin
            if (hit_c)
            begin
                // touch: younger entries age by one
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (match_v[i])
                    begin
                        rank_next[i] = '0;
                        if (in_kind_reg == lrukv_pkg::KIND_PUT)
                        begin
                            value_next[i] = in_val_reg;
                        end
                    end
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
            end
            else if (in_kind_reg == lrukv_pkg::KIND_PUT)
            begin
                // install: all other valid entries age by one
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (tgt_oh[i])
                    begin
                        valid_next[i] = 1'b1;
                        key_next[i]   = in_key_reg;
                        value_next[i] = in_val_reg;
                        rank_next[i]  = '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                if (full_c)
                begin
                    ev_next  = 1'b1;
                    evk_next = lru_key;
                end
                else if (|free_oh)
                begin
                    occ_next = occ_reg + 1'b1;
                end
            end

            if (in_kind_reg == lrukv_pkg::KIND_GET)
            begin
                rd_next = hit_c ? 32'(hit_val_s) : -32'sd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            valid_reg  <= '0;
            occ_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
            valid_reg  <= valid_next;
            occ_reg    <= occ_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_kind_reg <= kind;
            in_key_reg  <= lookup_key;
            in_val_reg  <= write_value;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_reg[i]   <= key_next[i];
            value_reg[i] <= value_next[i];
            rank_reg[i]  <= rank_next[i];
        end
        hit_reg <= hit_next;
        rd_reg  <= rd_next;
        ev_reg  <= ev_next;
        evk_reg <= evk_next;
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = rd_reg;
    assign evicted     = ev_reg;
    assign evicted_key = evk_reg;

endmodule

// File: tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking testbench for lru_key_value_cache_core.
// Get and put transactions go in through the start/busy handshake. The
// capacity register is reprogrammed over APB between phases: zero, one,
// sixteen, values above the cache size, and limits below the current fill.
// A behavioral LRU cache tracks slots, values and recency ranks, and each
// done strobe is compared field by field against the oldest prediction.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS = lrukv_pkg::CAPACITY_DEF;
    localparam int KEY_W  = lrukv_pkg::KEY_BITS_DEF;
    localparam int VAL_W  = lrukv_pkg::VALUE_BITS_DEF;
    localparam int RANK_W = $clog2(NSLOTS);

    typedef struct packed {
        logic                   hit;
        logic signed [31:0]     read_value;
        logic                   evicted;
        logic [KEY_W-1:0]       evicted_key;
    } access_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [lrukv_pkg::PADDR_BITS-1:0]    paddr = '0;
    logic [lrukv_pkg::PDATA_BITS-1:0]    pwdata = '0;
    logic [lrukv_pkg::PDATA_BITS-1:0]    prdata;
    logic                                pready;
    logic                                start = 1'b0;
    logic                                busy;
    logic                                kind = lrukv_pkg::KIND_GET;
    logic [KEY_W-1:0]                    lookup_key = '0;
    logic signed [VAL_W-1:0]             write_value = '0;
    logic                                done;
    logic                                hit;
    logic signed [31:0]                  read_value;
    logic                                evicted;
    logic [KEY_W-1:0]                    evicted_key;

    // shadow cache state
    logic                                slot_used [NSLOTS];
    logic [KEY_W-1:0]                    slot_tag  [NSLOTS];
    logic [VAL_W-1:0]                    slot_data [NSLOTS];
    logic [RANK_W-1:0]                   slot_age  [NSLOTS];
    logic [lrukv_pkg::CFG_BITS-1:0]      fill_count;
    logic [lrukv_pkg::CFG_BITS-1:0]      capacity_reg;

    access_result_t          pending_outcomes[$];
    int                      mismatch_count = 0;
    int                      idle_pct = 0;

    lru_key_value_cache_core i_dut (.*);

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // LRU predictor
    // ------------------------------------------------------------------------
    function automatic void make_newest(input int s);
        for (int i = 0; i < NSLOTS; i++)
            if (slot_used[i] && i != s && slot_age[i] < slot_age[s])
                slot_age[i] = slot_age[i] + 1'b1;
        slot_age[s] = '0;
    endfunction

    function automatic void place_entry(input int s, input logic [KEY_W-1:0] k,
                                        input logic [VAL_W-1:0] v);
        for (int i = 0; i < NSLOTS; i++)
            if (slot_used[i] && i != s)
                slot_age[i] = slot_age[i] + 1'b1;
        slot_used[s] = 1'b1;
        slot_tag[s]  = k;
        slot_data[s] = v;
        slot_age[s]  = '0;
    endfunction

    function automatic access_result_t lru_access(input logic op,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [VAL_W-1:0] v);
        access_result_t r;
        int found;
        int victim;
        int hole;
        int limit;
        r = '0;
        found = -1;
        victim = -1;
        hole = -1;
        limit = (capacity_reg == 0) ? 1 :
                (capacity_reg > NSLOTS) ? NSLOTS : int'(capacity_reg);
        for (int i = 0; i < NSLOTS; i++)
            if (found < 0 && slot_used[i] && slot_tag[i] == k)
                found = i;
        r.hit = (found >= 0);
        if (op == lrukv_pkg::KIND_GET) begin
            if (found >= 0) begin
                r.read_value = 32'(signed'(slot_data[found]));
                make_newest(found);
            end else begin
                r.read_value = -32'sd1;
            end
        end else if (found >= 0) begin
            slot_data[found] = v;
            make_newest(found);
        end else if (int'(fill_count) >= limit) begin
            for (int i = 0; i < NSLOTS; i++)
                if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                    victim = i;
            if (victim < 0) begin
                victim = 0;
                fill_count = lrukv_pkg::CFG_BITS'(1);
            end else begin
                r.evicted = 1'b1;
                r.evicted_key = slot_tag[victim];
                slot_used[victim] = 1'b0;
            end
            place_entry(victim, k, v);
        end else begin
            for (int i = 0; i < NSLOTS; i++)
                if (hole < 0 && !slot_used[i])
                    hole = i;
            if (hole >= 0) begin
                place_entry(hole, k, v);
                fill_count = fill_count + 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        access_result_t want;
        if (done === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                $error("result transaction with nothing outstanding");
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    mismatch_count++;
                end
                if (read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, read_value);
                    mismatch_count++;
                end
                if (evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, evicted);
                    mismatch_count++;
                end
                if (evicted_key !== want.evicted_key) begin
                    $error("evicted_key: expected 0x%04h, got 0x%04h",
                           want.evicted_key, evicted_key);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_access(input logic op, input logic [KEY_W-1:0] k,
                               input logic signed [VAL_W-1:0] v);
        int pause;
        pause = 0;
        if ($urandom_range(99) < idle_pct)
            pause = ($urandom_range(19) == 0) ? $urandom_range(40, 10)
                                              : $urandom_range(3, 1);
        if (pause > 0) begin
            start <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= op;
        lookup_key  <= k;
        write_value <= v;
        do @(posedge clk); while (busy !== 1'b0);
        pending_outcomes.push_back(lru_access(op, k, v));
    endtask

    task automatic drain_cache;
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_capacity(input logic [lrukv_pkg::PDATA_BITS-1:0] data);
        logic [lrukv_pkg::PDATA_BITS-1:0] readback;
        drain_cache();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lrukv_pkg::REG_CAPACITY_IDX, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        capacity_reg = data[lrukv_pkg::CFG_BITS-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== lrukv_pkg::PDATA_BITS'(capacity_reg)) begin
            $error("capacity_in_use: expected %0d, got %0d", capacity_reg, readback);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_basic_access;
        idle_pct = 30;
        send_access(lrukv_pkg::KIND_GET, 16'h0000, 32'sh7FFF_FFFF);
        send_access(lrukv_pkg::KIND_PUT, 16'h0000, 32'sh8000_0000);
        send_access(lrukv_pkg::KIND_PUT, 16'hFFFF, 32'sh7FFF_FFFF);
        send_access(lrukv_pkg::KIND_GET, 16'h0000, 32'sh0);
        send_access(lrukv_pkg::KIND_GET, 16'hFFFF, 32'sh0);
        send_access(lrukv_pkg::KIND_PUT, 16'h0000, -32'sd1);
        send_access(lrukv_pkg::KIND_GET, 16'h0000, 32'sh0);
        send_access(lrukv_pkg::KIND_GET, 16'h5A5A, 32'sh1234_5678);
        send_access(lrukv_pkg::KIND_PUT, 16'hA5A5, 32'sh0);
    endtask

    task automatic test_capacity_limits;
        idle_pct = 0;
        // zero acts as one, already below the current fill
        program_capacity(32'd0);
        send_access(lrukv_pkg::KIND_PUT, 16'h1111, 32'sd1);
        send_access(lrukv_pkg::KIND_GET, 16'hA5A5, 32'sd0);
        send_access(lrukv_pkg::KIND_PUT, 16'h2222, 32'sd2);
        program_capacity(32'd2);
        send_access(lrukv_pkg::KIND_PUT, 16'h3333, 32'sd3);
        send_access(lrukv_pkg::KIND_GET, 16'h1111, 32'sd0);
        // above the slot count clamps to the slot count
        program_capacity(32'd31);
        send_access(lrukv_pkg::KIND_PUT, 16'h4444, 32'sd4);
        // upper data bits are dropped by the register
        program_capacity(32'hFFFF_FFE1);
        send_access(lrukv_pkg::KIND_PUT, 16'h5555, 32'sd5);
        send_access(lrukv_pkg::KIND_PUT, 16'h5555, 32'sd6);
        send_access(lrukv_pkg::KIND_GET, 16'h5555, 32'sd0);
        program_capacity(32'd16);
    endtask

    task automatic test_random_traffic;
        logic [lrukv_pkg::CFG_BITS-1:0] phase_caps [10];
        logic [KEY_W-1:0]               key_pool[$];
        int                             limit;
        logic [KEY_W-1:0]               k;
        logic signed [31:0]             v;
        phase_caps = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5, 5'd17, 5'd3, 5'd16, 5'd9};
        for (int p = 0; p < 10; p++) begin
            program_capacity({$urandom_range(1) ? 27'($urandom) : 27'd0, phase_caps[p]});
            idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 15 : 50;
            limit = (phase_caps[p] == 0) ? 1 :
                    (phase_caps[p] > NSLOTS) ? NSLOTS : int'(phase_caps[p]);
            key_pool.delete();
            repeat (limit + $urandom_range(6, 1)) key_pool.push_back(KEY_W'($urandom));
            repeat (160) begin
                if ($urandom_range(9) == 0)
                    k = KEY_W'($urandom);
                else
                    k = key_pool[$urandom_range(key_pool.size() - 1)];
                case ($urandom_range(15))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = -32'sd1;
                    3:       v = 32'sd0;
                    default: v = $urandom;
                endcase
                send_access($urandom_range(1) ? lrukv_pkg::KIND_PUT : lrukv_pkg::KIND_GET,
                            k, v);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_tag[i]  = '0;
            slot_data[i] = '0;
            slot_age[i]  = '0;
        end
        fill_count   = '0;
        capacity_reg = lrukv_pkg::CAP_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_access();
        test_capacity_limits();
        test_random_traffic();

        drain_cache();
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
rtl/lrukv_pkg.sv
rtl/lrukv_regs.sv
rtl/lru_key_value_cache_core.sv
tb/tb_top.sv
